@@ rtl/iiat_pkg.sv @@
// Shared types, constants and helpers of the integral image adaptive threshold unit.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`default_nettype none

package iiat_pkg;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 9;
   localparam int CFG_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 27;
   localparam int ROW_SUM_W  = 17;
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   localparam logic [CFG_W-1:0] DIM_RESET    = 10'd512;
   localparam logic [PIX_W-1:0] WINDOW_RESET = 8'd21;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

   // grey = floor(s/3) for s <= 765 via reciprocal 683/2048
   localparam int GREY_SUM_W  = 10;
   localparam int GREY_PROD_W = 20;
   localparam int DIV3_RECIP  = 683;
   localparam int DIV3_SHIFT  = 11;

   typedef enum logic [1:0] {
      RSP_LOAD_OK      = 2'd0,
      RSP_QUERY_OK     = 2'd1,
      RSP_NOT_LOADED   = 2'd2,
      RSP_OUT_OF_RANGE = 2'd3
   } rsp_code_type;

   typedef enum logic [1:0] {
      MUL_ROW_Q,
      MUL_ROW_LO,
      MUL_ROW_HI,
      MUL_AREA
   } mul_sel_type;

   typedef enum logic [2:0] {
      SRD_ABOVE,
      SRD_HI_X2,
      SRD_LO_X2,
      SRD_HI_X1,
      SRD_LO_X1
   } sum_rd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic           accept;
      logic           csr_write;
      logic           ld_prep;
      logic           ld_write;
      logic           corner_load;
      logic           mul_en;
      mul_sel_type    mul_sel;
      logic           sum_rd_en;
      sum_rd_sel_type sum_rd_sel;
      logic           grey_rd_en;
      acc_op_type     acc_op;
      logic           div_init;
      logic           div_step;
      logic           resp_load;
      rsp_code_type   resp_code;
   } iiat_cmd_type;

   typedef struct packed {
      logic action;
      logic frame_ready;
      logic range_bad;
      logic div_last;
   } iiat_status_type;

   function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
      logic [GREY_SUM_W-1:0]  s;
      logic [GREY_PROD_W-1:0] p;
      s = GREY_SUM_W'(r) + GREY_SUM_W'(g) + GREY_SUM_W'(b);
      p = GREY_PROD_W'(s) * GREY_PROD_W'(DIV3_RECIP);
      return p[DIV3_SHIFT +: PIX_W];
   endfunction

endpackage

`default_nettype wire

@@ rtl/iiat_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used for the grey and summed-area stores.
`default_nettype none

module iiat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/iiat_datapath.sv @@
// Datapath: configuration registers, load counters, corner math, shared multiplier,
// corner accumulator, restoring divider and response registers. Uses iiat_pkg, iiat_ram.
`default_nettype none

module iiat_datapath #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire iiat_pkg::iiat_cmd_type            cmd,
   output iiat_pkg::iiat_status_type              status,
   input  wire logic [iiat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [iiat_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic                              req_action,
   input  wire logic [iiat_pkg::PIX_W-1:0]        req_red_in,
   input  wire logic [iiat_pkg::PIX_W-1:0]        req_green_in,
   input  wire logic [iiat_pkg::PIX_W-1:0]        req_blue_in,
   input  wire logic [iiat_pkg::COORD_W-1:0]      req_query_x,
   input  wire logic [iiat_pkg::COORD_W-1:0]      req_query_y,
   output logic      [1:0]                        rsp_status,
   output logic                                   rsp_is_black,
   output logic      [iiat_pkg::PIX_W-1:0]        rsp_local_mean,
   output logic                                   rsp_frame_complete
);

   import iiat_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADW   = $clog2(DEPTH);
   localparam int AW    = XW + YW;
   localparam int PW    = YW + WW;
   localparam int CXW   = (WW > CFG_W) ? WW : CFG_W;
   localparam int CYW   = (HW > CFG_W) ? HW : CFG_W;

   // configuration
   logic [CFG_W-1:0]     width_ff, height_ff;
   logic [PIX_W-1:0]     window_ff;
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic                 cfg_hit;

   // latched request
   logic                 action_ff;
   logic [PIX_W-1:0]     red_ff, green_ff, blue_ff;
   logic [COORD_W-1:0]   qx_ff, qy_ff;

   // load state
   logic [XW-1:0]        col_ff;
   logic [YW-1:0]        row_ff;
   logic [ADW-1:0]       load_addr_ff;
   logic [ROW_SUM_W-1:0] row_sum_ff;
   logic                 frame_ready_ff;
   logic [PIX_W-1:0]     grey_ld_ff;
   logic                 col_last, row_last, frame_done;
   logic [ROW_SUM_W-1:0] row_new;
   logic [SUM_W-1:0]     above_v, sum_wr_data;

   // corners
   logic [CXW-1:0]       qx_c, side_xc, w_c, xs_c, x1_c, x2_c;
   logic [CYW-1:0]       qy_c, side_yc, h_c, ys_c, y1_c, y2_c;
   logic [XW-1:0]        x1_ff, x2_ff, qx_xw;
   logic [YW-1:0]        y1_ff, y2_ff;

   // multiplier and bases
   logic [YW-1:0]        mul_a;
   logic [WW-1:0]        mul_b;
   logic [PW-1:0]        mul_p;
   logic [ADW-1:0]       base_q_ff, base_lo_ff, base_hi_ff;
   logic [AW-1:0]        area_ff;

   // memories
   logic [ADW-1:0]       sum_rd_addr, grey_rd_addr;
   logic [SUM_W-1:0]     sum_rd_data;
   logic [PIX_W-1:0]     grey_rd_data;

   // accumulate and divide
   logic [SUM_W-1:0]     acc_ff, dvd_ff;
   logic [AW-1:0]        rem_ff, rem_next;
   logic [AW:0]          trial;
   logic                 fits;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PIX_W-1:0]     mean_v;

   // effective image size: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  cfg_hit = 1'b1;
         REG_IMAGE_HEIGHT: cfg_hit = 1'b1;
         REG_WINDOW_SIZE:  cfg_hit = 1'b1;
         default:          cfg_hit = 1'b0;
      endcase
   end

   // window corners, clamped to the image
   always_comb begin
      qx_c    = CXW'(qx_ff);
      qy_c    = CYW'(qy_ff);
      side_xc = CXW'(window_ff[PIX_W-1:1]);
      side_yc = CYW'(window_ff[PIX_W-1:1]);
      w_c     = CXW'(w_eff);
      h_c     = CYW'(h_eff);
      xs_c    = qx_c + side_xc;
      ys_c    = qy_c + side_yc;
      x2_c    = (xs_c >= w_c) ? w_c - CXW'(1) : xs_c;
      y2_c    = (ys_c >= h_c) ? h_c - CYW'(1) : ys_c;
      x1_c    = (qx_c > side_xc) ? qx_c - side_xc - CXW'(1) : '0;
      y1_c    = (qy_c > side_yc) ? qy_c - side_yc - CYW'(1) : '0;
   end

   assign qx_xw = XW'(qx_ff);

   assign status.action      = action_ff;
   assign status.frame_ready = frame_ready_ff;
   assign status.range_bad   = (qx_c >= w_c) || (qy_c >= h_c);
   assign status.div_last    = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));

   // load step arithmetic
   assign col_last    = (WW'(col_ff) + WW'(1)) == w_eff;
   assign row_last    = (HW'(row_ff) + HW'(1)) == h_eff;
   assign frame_done  = col_last && row_last;
   assign row_new     = ((col_ff == '0) ? '0 : row_sum_ff) + ROW_SUM_W'(grey_ld_ff);
   assign above_v     = (row_ff == '0) ? '0 : sum_rd_data;
   assign sum_wr_data = above_v + SUM_W'(row_new);

   // shared multiplier: row bases and window area
   always_comb begin
      case (cmd.mul_sel)
         MUL_ROW_Q: begin
            mul_a = YW'(qy_ff);
            mul_b = w_eff;
         end
         MUL_ROW_LO: begin
            mul_a = y1_ff;
            mul_b = w_eff;
         end
         MUL_ROW_HI: begin
            mul_a = y2_ff;
            mul_b = w_eff;
         end
         default: begin
            mul_a = y2_ff - y1_ff;
            mul_b = WW'(x2_ff - x1_ff);
         end
      endcase
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      case (cmd.sum_rd_sel)
         SRD_ABOVE: sum_rd_addr = load_addr_ff - ADW'(w_eff);
         SRD_HI_X2: sum_rd_addr = base_hi_ff + ADW'(x2_ff);
         SRD_LO_X2: sum_rd_addr = base_lo_ff + ADW'(x2_ff);
         SRD_HI_X1: sum_rd_addr = base_hi_ff + ADW'(x1_ff);
         SRD_LO_X1: sum_rd_addr = base_lo_ff + ADW'(x1_ff);
         default:   sum_rd_addr = load_addr_ff;
      endcase
   end

   assign grey_rd_addr = base_q_ff + ADW'(qx_xw);

   // one restoring division step a cycle
   assign trial    = {rem_ff, dvd_ff[SUM_W-1]};
   assign fits     = trial >= {1'b0, area_ff};
   assign rem_next = fits ? AW'(trial - {1'b0, area_ff}) : trial[AW-1:0];
   assign mean_v   = (area_ff == '0) ? '0 : dvd_ff[PIX_W-1:0];

   iiat_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (cmd.ld_write),
      .wr_addr (load_addr_ff),
      .wr_data (sum_wr_data),
      .rd_en   (cmd.sum_rd_en),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rd_data)
   );

   iiat_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_grey_ram (
      .clock   (clock),
      .wr_en   (cmd.ld_write),
      .wr_addr (load_addr_ff),
      .wr_data (grey_ld_ff),
      .rd_en   (cmd.grey_rd_en),
      .rd_addr (grey_rd_addr),
      .rd_data (grey_rd_data)
   );

   // configuration and load state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= DIM_RESET;
         height_ff      <= DIM_RESET;
         window_ff      <= WINDOW_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         load_addr_ff   <= '0;
         row_sum_ff     <= '0;
         frame_ready_ff <= 1'b0;
      end else if (cmd.csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            REG_WINDOW_SIZE:  window_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
         if (cfg_hit) begin
            col_ff         <= '0;
            row_ff         <= '0;
            load_addr_ff   <= '0;
            row_sum_ff     <= '0;
            frame_ready_ff <= 1'b0;
         end
      end else if (cmd.ld_prep) begin
         // a load after a complete frame starts a new one
         if (frame_ready_ff) begin
            col_ff         <= '0;
            row_ff         <= '0;
            load_addr_ff   <= '0;
            row_sum_ff     <= '0;
            frame_ready_ff <= 1'b0;
         end
      end else if (cmd.ld_write) begin
         row_sum_ff <= row_new;
         if (col_last) begin
            col_ff <= '0;
            if (row_last) begin
               row_ff         <= '0;
               load_addr_ff   <= '0;
               frame_ready_ff <= 1'b1;
            end else begin
               row_ff       <= row_ff + YW'(1);
               load_addr_ff <= load_addr_ff + ADW'(1);
            end
         end else begin
            col_ff       <= col_ff + XW'(1);
            load_addr_ff <= load_addr_ff + ADW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_init) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         red_ff    <= req_red_in;
         green_ff  <= req_green_in;
         blue_ff   <= req_blue_in;
         qx_ff     <= req_query_x;
         qy_ff     <= req_query_y;
      end
      if (cmd.ld_prep) begin
         grey_ld_ff <= grey_of(red_ff, green_ff, blue_ff);
      end
      if (cmd.corner_load) begin
         x1_ff <= XW'(x1_c);
         x2_ff <= XW'(x2_c);
         y1_ff <= YW'(y1_c);
         y2_ff <= YW'(y2_c);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_ROW_Q:  base_q_ff  <= ADW'(mul_p);
            MUL_ROW_LO: base_lo_ff <= ADW'(mul_p);
            MUL_ROW_HI: base_hi_ff <= ADW'(mul_p);
            default:    area_ff    <= AW'(mul_p);
         endcase
      end
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= sum_rd_data;
         ACC_SUB:  acc_ff <= acc_ff - sum_rd_data;
         default:  acc_ff <= acc_ff;
      endcase
      if (cmd.div_init) begin
         dvd_ff <= acc_ff + sum_rd_data;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[SUM_W-2:0], fits};
         rem_ff <= rem_next;
      end
      if (cmd.resp_load) begin
         rsp_status <= cmd.resp_code;
         case (cmd.resp_code)
            RSP_LOAD_OK: begin
               rsp_is_black       <= 1'b0;
               rsp_local_mean     <= '0;
               rsp_frame_complete <= frame_done;
            end
            RSP_QUERY_OK: begin
               rsp_is_black       <= grey_rd_data < mean_v;
               rsp_local_mean     <= mean_v;
               rsp_frame_complete <= 1'b0;
            end
            default: begin
               rsp_is_black       <= 1'b0;
               rsp_local_mean     <= '0;
               rsp_frame_complete <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/iiat_ctrl.sv @@
// Controller: sequences loads, queries and configuration writes for the datapath.
// Uses iiat_pkg for the command and status structs.
`default_nettype none

module iiat_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   output logic                           rsp_valid,
   output iiat_pkg::iiat_cmd_type         cmd,
   input  wire iiat_pkg::iiat_status_type status
);

   import iiat_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LD_PREP,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_Q_MUL_Q,
      ST_Q_MUL_LO,
      ST_Q_MUL_HI,
      ST_Q_RD_A,
      ST_Q_RD_B,
      ST_Q_RD_C,
      ST_Q_RD_D,
      ST_Q_AREA,
      ST_Q_DIV,
      ST_Q_DONE
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.csr_write = csr_valid && !start;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.action) begin
               state_in = ST_LD_PREP;
            end else if (!status.frame_ready) begin
               cmd.resp_load = 1'b1;
               cmd.resp_code = RSP_NOT_LOADED;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.range_bad) begin
               cmd.resp_load = 1'b1;
               cmd.resp_code = RSP_OUT_OF_RANGE;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.corner_load = 1'b1;
               state_in        = ST_Q_MUL_Q;
            end
         end
         ST_LD_PREP: begin
            cmd.ld_prep = 1'b1;
            state_in    = ST_LD_READ;
         end
         ST_LD_READ: begin
            cmd.sum_rd_en  = 1'b1;
            cmd.sum_rd_sel = SRD_ABOVE;
            state_in       = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            cmd.ld_write  = 1'b1;
            cmd.resp_load = 1'b1;
            cmd.resp_code = RSP_LOAD_OK;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_Q_MUL_Q: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW_Q;
            state_in    = ST_Q_MUL_LO;
         end
         ST_Q_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW_LO;
            state_in    = ST_Q_MUL_HI;
         end
         ST_Q_MUL_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW_HI;
            state_in    = ST_Q_RD_A;
         end
         ST_Q_RD_A: begin
            cmd.sum_rd_en  = 1'b1;
            cmd.sum_rd_sel = SRD_HI_X2;
            cmd.grey_rd_en = 1'b1;
            state_in       = ST_Q_RD_B;
         end
         // each table read's data lands in the next cycle and folds into the corner sum
         ST_Q_RD_B: begin
            cmd.sum_rd_en  = 1'b1;
            cmd.sum_rd_sel = SRD_LO_X2;
            cmd.acc_op     = ACC_LOAD;
            state_in       = ST_Q_RD_C;
         end
         ST_Q_RD_C: begin
            cmd.sum_rd_en  = 1'b1;
            cmd.sum_rd_sel = SRD_HI_X1;
            cmd.acc_op     = ACC_SUB;
            state_in       = ST_Q_RD_D;
         end
         ST_Q_RD_D: begin
            cmd.sum_rd_en  = 1'b1;
            cmd.sum_rd_sel = SRD_LO_X1;
            cmd.acc_op     = ACC_SUB;
            state_in       = ST_Q_AREA;
         end
         ST_Q_AREA: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_AREA;
            cmd.div_init = 1'b1;
            state_in     = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_DONE: begin
            cmd.resp_load = 1'b1;
            cmd.resp_code = RSP_QUERY_OK;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/integral_image_adaptive_threshold_unit.sv @@
// Integral image adaptive threshold unit: loads pixels into a summed-area table and
// answers local-mean threshold queries. A load strobes its result after the decode,
// prep, read and write states; a query after four table reads on one port and a 27-step
// divider; a refused query after decode. A new item is taken in the cycle its result
// shows. Reset is synchronous and restores the size registers; the pixel and table
// memories are not cleared, they hold data only once a frame is loaded.
`default_nettype none

module integral_image_adaptive_threshold_unit #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_action,
   input  wire logic [iiat_pkg::PIX_W-1:0]       req_red_in,
   input  wire logic [iiat_pkg::PIX_W-1:0]       req_green_in,
   input  wire logic [iiat_pkg::PIX_W-1:0]       req_blue_in,
   input  wire logic [iiat_pkg::COORD_W-1:0]     req_query_x,
   input  wire logic [iiat_pkg::COORD_W-1:0]     req_query_y,
   output logic                                  rsp_valid,
   output logic      [1:0]                       rsp_status,
   output logic                                  rsp_is_black,
   output logic      [iiat_pkg::PIX_W-1:0]       rsp_local_mean,
   output logic                                  rsp_frame_complete,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [iiat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [iiat_pkg::CFG_W-1:0]       csr_wdata
);

   import iiat_pkg::*;

   iiat_cmd_type    cmd;
   iiat_status_type status;

   iiat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   iiat_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_red_in         (req_red_in),
      .req_green_in       (req_green_in),
      .req_blue_in        (req_blue_in),
      .req_query_x        (req_query_x),
      .req_query_y        (req_query_y),
      .rsp_status         (rsp_status),
      .rsp_is_black       (rsp_is_black),
      .rsp_local_mean     (rsp_local_mean),
      .rsp_frame_complete (rsp_frame_complete)
   );

endmodule

`default_nettype wire

@@ rtl/iiat_checker.sv @@
// Port-level checks for the integral image adaptive threshold unit, bound to the top level.
// Uses iiat_pkg for the result status codes.
`default_nettype none

module iiat_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [1:0]                  rsp_status,
   input wire logic                        rsp_is_black,
   input wire logic [iiat_pkg::PIX_W-1:0]  rsp_local_mean,
   input wire logic                        csr_ready
);

   import iiat_pkg::*;

   // each item strobes once, and two results never strobe back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the unit busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result shown without finishing an item");

   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != RSP_QUERY_OK) |-> (!rsp_is_black && rsp_local_mean == '0))
      else $error("threshold fields set on a non-query result");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (!busy && !start))
      else $error("configuration port open while an item is in flight");

endmodule

bind integral_image_adaptive_threshold_unit iiat_checker u_iiat_checker (.*);

`default_nettype wire

@@ tb/integral_image_adaptive_threshold_unit_test.sv @@
// Self-checking testbench for the integral image adaptive threshold unit: a directed
// table, then random frame load and query sequences, checked against a local predictor.
// Depends on iiat_pkg and the integral_image_adaptive_threshold_unit top level.
`timescale 1ns / 100ps

module integral_image_adaptive_threshold_unit_test;
   import iiat_pkg::*;

   localparam int MAX_DIM      = 512;
   localparam int PIXELS       = MAX_DIM * MAX_DIM;
   localparam int ITEM_BUDGET  = 850;
   localparam int DRAIN_CYCLES = 50;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic               action;
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [COORD_W-1:0] qx;
      logic [COORD_W-1:0] qy;
   } pixel_req_type;

   typedef struct packed {
      rsp_code_type     status;
      logic             is_black;
      logic [PIX_W-1:0] mean;
      logic             frame_complete;
   } pixel_result_type;

   typedef enum bit {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CFG_W-1:0]       data;
      pixel_req_type          req;
      bit                     typed;
      pixel_result_type       want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [PIX_W-1:0]     req_red_in;
   logic [PIX_W-1:0]     req_green_in;
   logic [PIX_W-1:0]     req_blue_in;
   logic [COORD_W-1:0]   req_query_x;
   logic [COORD_W-1:0]   req_query_y;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic                 rsp_is_black;
   logic [PIX_W-1:0]     rsp_local_mean;
   logic                 rsp_frame_complete;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // predictor state
   bit [CFG_W-1:0]     cfg_width  = DIM_RESET;
   bit [CFG_W-1:0]     cfg_height = DIM_RESET;
   bit [PIX_W-1:0]     cfg_window = WINDOW_RESET;
   int unsigned        fill_col;
   int unsigned        fill_row;
   bit [ROW_SUM_W-1:0] row_acc;
   bit                 frame_full;
   bit [PIX_W-1:0]     grey_mem [PIXELS];
   bit [SUM_W-1:0]     sat_mem [PIXELS];

   pixel_result_type awaited_results [$];
   stim_row_type     directed [$];
   int unsigned      items_sent;
   int unsigned      failures;
   bit               gaps_on;

   integral_image_adaptive_threshold_unit #(
      .MAX_WIDTH (MAX_DIM),
      .MAX_HEIGHT(MAX_DIM)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_query_x       (req_query_x),
      .req_query_y       (req_query_y),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_is_black      (rsp_is_black),
      .rsp_local_mean    (rsp_local_mean),
      .rsp_frame_complete(rsp_frame_complete),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("integral_image_adaptive_threshold_unit_test: FAIL");
      $finish;
   end

   function automatic int unsigned eff_dim(input bit [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (32'(v) > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic void restart_fill();
      row_acc    = '0;
      fill_col   = 0;
      fill_row   = 0;
      frame_full = 1'b0;
   endfunction

   function automatic void csr_apply(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = data;
         REG_IMAGE_HEIGHT: cfg_height = data;
         REG_WINDOW_SIZE:  cfg_window = data[PIX_W-1:0];
         default:          return;
      endcase
      restart_fill();
   endfunction

   function automatic pixel_result_type threshold_predict(input pixel_req_type it);
      int unsigned      w, h, grey, idx, side, x, y, x1, y1, x2, y2, area;
      bit [SUM_W-1:0]   above, corner_sum;
      pixel_result_type res;
      w   = eff_dim(cfg_width);
      h   = eff_dim(cfg_height);
      res = '0;
      if (it.action == ACT_LOAD) begin
         grey = (32'(it.red) + 32'(it.green) + 32'(it.blue)) / 3;
         if (frame_full || fill_col >= w || fill_row >= h) restart_fill();
         if (fill_col == 0) row_acc = '0;
         row_acc = row_acc + ROW_SUM_W'(grey);
         idx = fill_row * w + fill_col;
         above = (fill_row > 0) ? sat_mem[idx - w] : '0;
         grey_mem[idx] = PIX_W'(grey);
         sat_mem[idx]  = above + SUM_W'(row_acc);
         fill_col++;
         if (fill_col >= w) begin
            fill_col = 0;
            fill_row++;
            if (fill_row >= h) begin
               fill_row   = 0;
               frame_full = 1'b1;
               res.frame_complete = 1'b1;
            end
         end
         return res;
      end
      if (!frame_full) begin
         res.status = RSP_NOT_LOADED;
         return res;
      end
      x = 32'(it.qx);
      y = 32'(it.qy);
      if (x >= w || y >= h) begin
         res.status = RSP_OUT_OF_RANGE;
         return res;
      end
      side = 32'(cfg_window) / 2;
      x1 = (x >= side + 1) ? x - side - 1 : 0;
      y1 = (y >= side + 1) ? y - side - 1 : 0;
      x2 = (x + side >= w) ? w - 1 : x + side;
      y2 = (y + side >= h) ? h - 1 : y + side;
      area = (x2 - x1) * (y2 - y1);
      corner_sum = sat_mem[y2 * w + x2] - sat_mem[y1 * w + x2]
                   - sat_mem[y2 * w + x1] + sat_mem[y1 * w + x1];
      res.status = RSP_QUERY_OK;
      if (area != 0) res.mean = PIX_W'(32'(corner_sum) / area);
      res.is_black = (grey_mem[y * w + x] < res.mean);
      return res;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.data  = data;
      row.req   = '0;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic stim_row_type pixel_row(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b, input logic last);
      stim_row_type row;
      row = csr_row(REG_IMAGE_WIDTH, '0);
      row.kind       = ROW_ITEM;
      row.req.action = ACT_LOAD;
      row.req.red    = r;
      row.req.green  = g;
      row.req.blue   = b;
      row.typed      = 1'b1;
      row.want.status         = RSP_LOAD_OK;
      row.want.frame_complete = last;
      return row;
   endfunction

   function automatic stim_row_type query_row(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input bit typed, input rsp_code_type code);
      stim_row_type row;
      row = csr_row(REG_IMAGE_WIDTH, '0);
      row.kind       = ROW_ITEM;
      row.req.action = ACT_QUERY;
      row.req.qx     = x;
      row.req.qy     = y;
      row.typed      = typed;
      row.want.status = code;
      return row;
   endfunction

   function automatic pixel_req_type random_load();
      pixel_req_type it;
      it.action = ACT_LOAD;
      it.red    = PIX_W'($urandom_range(0, 255));
      it.green  = PIX_W'($urandom_range(0, 255));
      it.blue   = PIX_W'($urandom_range(0, 255));
      it.qx     = COORD_W'($urandom_range(0, MAX_DIM - 1));
      it.qy     = COORD_W'($urandom_range(0, MAX_DIM - 1));
      return it;
   endfunction

   function automatic pixel_req_type random_query(input int unsigned w, input int unsigned h,
                                                  input bit in_range);
      pixel_req_type it;
      it = random_load();
      it.action = ACT_QUERY;
      if (in_range) begin
         it.qx = COORD_W'($urandom_range(0, w - 1));
         it.qy = COORD_W'($urandom_range(0, h - 1));
      end else if (w < MAX_DIM && $urandom_range(0, 1) == 1) begin
         it.qx = COORD_W'($urandom_range(w, MAX_DIM - 1));
      end else if (h < MAX_DIM) begin
         it.qy = COORD_W'($urandom_range(h, MAX_DIM - 1));
      end
      return it;
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim();
      int unsigned p;
      p = $urandom_range(0, 19);
      if (p < 2) return '0;
      if (p < 16) return CFG_W'($urandom_range(1, 6));
      return CFG_W'($urandom_range(7, 20));
   endfunction

   function automatic logic [CFG_W-1:0] pick_window();
      int unsigned p;
      logic [PIX_W-1:0] win;
      p = $urandom_range(0, 19);
      if (p < 12) win = PIX_W'($urandom_range(1, 9));
      else if (p < 17) win = PIX_W'($urandom_range(10, 255));
      else if (p < 19) win = 8'd255;
      else win = 8'd1;
      // upper data bits are dropped by the window register
      return {2'($urandom_range(0, 3)), win};
   endfunction

   task automatic idle_gap();
      int unsigned n, p;
      n = 0;
      p = $urandom_range(0, 99);
      if (!gaps_on || p < 55) n = 0;
      else if (p < 85) n = $urandom_range(1, 4);
      else if (p < 97) n = $urandom_range(5, 15);
      else n = $urandom_range(16, 60);
      repeat (n) @(negedge clock) start <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock) start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_item(input pixel_req_type it, input bit typed,
                            input pixel_result_type want);
      pixel_result_type predicted;
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= it.action;
      req_red_in   <= it.red;
      req_green_in <= it.green;
      req_blue_in  <= it.blue;
      req_query_x  <= it.qx;
      req_query_y  <= it.qy;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = threshold_predict(it);
      awaited_results.push_back(typed ? want : predicted);
      items_sent++;
      idle_gap();
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_apply(idx, data);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // probe_at places a query right after that load, at or beyond n means none
   task automatic load_frame(input int unsigned n, input int unsigned probe_at);
      int unsigned k;
      for (k = 0; k < n; k++) begin
         send_item(random_load(), 1'b0, '0);
         if (k == probe_at) send_item(random_query(MAX_DIM, MAX_DIM, 1'b1), 1'b0, '0);
      end
   endtask

   task automatic query_burst(input int unsigned w, input int unsigned h);
      repeat ($urandom_range(3, 10))
         send_item(random_query(w, h, $urandom_range(0, 5) != 0), 1'b0, '0);
   endtask

   // shape 0: small random frame, 1: full-width line, 2: full-height column
   task automatic run_phase(input int shape);
      int unsigned          we, he, style, rot, k, n;
      logic [CFG_W-1:0]     wval, hval, winval;
      logic [CSR_IDX_W-1:0] order [3];
      order   = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_SIZE};
      gaps_on = ($urandom_range(0, 4) != 0);
      case (shape)
         1: begin
            wval   = 10'd1023;
            hval   = 10'd1;
            winval = 10'd255;
         end
         2: begin
            wval   = 10'd1;
            hval   = 10'd512;
            winval = pick_window();
         end
         default: begin
            wval   = pick_dim();
            hval   = pick_dim();
            winval = pick_window();
         end
      endcase
      rot = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
         if (shape != 0 || $urandom_range(0, 3) != 0) begin
            case (order[(rot + k) % 3])
               REG_IMAGE_WIDTH:  write_csr(REG_IMAGE_WIDTH, wval);
               REG_IMAGE_HEIGHT: write_csr(REG_IMAGE_HEIGHT, hval);
               default:          write_csr(REG_WINDOW_SIZE, winval);
            endcase
         end
      end
      if ($urandom_range(0, 7) == 0) write_csr(REG_UNMAPPED, CFG_W'($urandom_range(0, 1023)));
      we = eff_dim(cfg_width);
      he = eff_dim(cfg_height);
      style = (shape != 0) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) query_burst(we, he);
      if (style < 7) begin
         load_frame(we * he, (style == 1) ? (we * he) / 2 : PIXELS);
         // hold the sender until the frame is fully answered
         if (style == 2) drain_results();
         query_burst(we, he);
         if (style == 3) begin
            // a load after a complete frame starts a new one
            load_frame(we * he, 0);
            query_burst(we, he);
         end
      end else begin
         n = $urandom_range(0, we * he - 1);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
               send_item(random_query(we, he, $urandom_range(0, 3) != 0), 1'b0, '0);
            send_item(random_load(), 1'b0, '0);
         end
         query_burst(we, he);
      end
   endtask

   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_results.size() == 0) begin
            $error("result with no item pending: status %0d", rsp_status);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_is_black !== want.is_black) begin
               $error("is_black: expected %0d, got %0d", want.is_black, rsp_is_black);
               failures++;
            end
            if (rsp_local_mean !== want.mean) begin
               $error("local_mean: expected %0d, got %0d", want.mean, rsp_local_mean);
               failures++;
            end
            if (rsp_frame_complete !== want.frame_complete) begin
               $error("frame_complete: expected %0d, got %0d", want.frame_complete,
                      rsp_frame_complete);
               failures++;
            end
         end
      end
   end

   initial begin
      int i;
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_LOAD;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      req_query_x  = '0;
      req_query_y  = '0;
      csr_valid    = 1'b0;
      csr_index    = REG_IMAGE_WIDTH;
      csr_wdata    = '0;
      items_sent   = 0;
      failures     = 0;
      gaps_on      = 1'b1;
      restart_fill();

      directed = '{
         query_row(9'd5, 9'd7, 1'b1, RSP_NOT_LOADED),
         // zero width acts as one: a single pixel frame
         csr_row(REG_IMAGE_WIDTH, 10'd0),
         csr_row(REG_IMAGE_HEIGHT, 10'd1),
         pixel_row(8'd255, 8'd255, 8'd255, 1'b1),
         query_row(9'd0, 9'd0, 1'b1, RSP_QUERY_OK),
         query_row(9'd1, 9'd0, 1'b1, RSP_OUT_OF_RANGE),
         query_row(9'd0, 9'd511, 1'b1, RSP_OUT_OF_RANGE),
         csr_row(REG_IMAGE_WIDTH, 10'd3),
         csr_row(REG_IMAGE_HEIGHT, 10'd2),
         csr_row(REG_WINDOW_SIZE, 10'd1),
         pixel_row(8'd0, 8'd0, 8'd0, 1'b0),
         pixel_row(8'd255, 8'd255, 8'd255, 1'b0),
         query_row(9'd0, 9'd0, 1'b1, RSP_NOT_LOADED),
         pixel_row(8'd1, 8'd2, 8'd3, 1'b0),
         pixel_row(8'd200, 8'd100, 8'd0, 1'b0),
         pixel_row(8'd10, 8'd20, 8'd30, 1'b0),
         pixel_row(8'd0, 8'd255, 8'd0, 1'b1),
         query_row(9'd1, 9'd1, 1'b0, RSP_QUERY_OK),
         query_row(9'd2, 9'd1, 1'b0, RSP_QUERY_OK),
         // window of one at the corner has no area, so white
         query_row(9'd0, 9'd0, 1'b1, RSP_QUERY_OK),
         query_row(9'd3, 9'd0, 1'b1, RSP_OUT_OF_RANGE),
         // unmapped register leaves the loaded frame alone
         csr_row(REG_UNMAPPED, 10'd1023),
         query_row(9'd2, 9'd1, 1'b0, RSP_QUERY_OK),
         csr_row(REG_WINDOW_SIZE, 10'd255),
         query_row(9'd1, 9'd1, 1'b1, RSP_NOT_LOADED),
         csr_row(REG_IMAGE_WIDTH, 10'd2),
         csr_row(REG_IMAGE_HEIGHT, 10'd2),
         pixel_row(8'd90, 8'd90, 8'd90, 1'b0),
         pixel_row(8'd30, 8'd30, 8'd30, 1'b0),
         pixel_row(8'd255, 8'd0, 8'd0, 1'b0),
         pixel_row(8'd200, 8'd200, 8'd200, 1'b1),
         query_row(9'd1, 9'd1, 1'b0, RSP_QUERY_OK),
         query_row(9'd0, 9'd1, 1'b0, RSP_QUERY_OK)
      };

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (i = 0; i < directed.size(); i++) begin
         if (directed[i].kind == ROW_CSR) write_csr(directed[i].idx, directed[i].data);
         else send_item(directed[i].req, directed[i].typed, directed[i].want);
      end

      // one full-size line or column frame, then small random frames up to the budget
      run_phase(int'($urandom_range(1, 2)));
      while (items_sent < ITEM_BUDGET) run_phase(0);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("integral_image_adaptive_threshold_unit_test: PASS");
      end else begin
         $display("integral_image_adaptive_threshold_unit_test: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/iiat_pkg.sv
rtl/iiat_ram.sv
rtl/iiat_datapath.sv
rtl/iiat_ctrl.sv
rtl/integral_image_adaptive_threshold_unit.sv
rtl/iiat_checker.sv
tb/integral_image_adaptive_threshold_unit_test.sv
